[sv/klb_pkg.sv]
// Shared constants, types and glyph class functions for the kinsoku line breaker.
package klb_pkg;

  localparam int MAX_GLYPHS = 32;
  localparam int MAX_LINES  = 64;
  localparam int CP_W       = 21;
  localparam int ADV_W      = 22;
  localparam int GADDR_W    = $clog2(MAX_GLYPHS);
  localparam int CNT_W      = $clog2(MAX_GLYPHS + 1);
  localparam int LADDR_W    = $clog2(MAX_LINES);
  localparam int LCNT_W     = $clog2(MAX_LINES + 1);
  localparam int EXT_W      = ADV_W + GADDR_W;
  localparam int OEXT_W     = 24;
  localparam int OFS_W      = 25;
  localparam int GW         = CP_W + ADV_W;
  localparam int LW         = 2 * CNT_W + EXT_W;
  localparam int IDX_W      = 2;
  localparam int CFG_W      = 22;

  localparam logic [IDX_W-1:0] REG_WRAP  = 2'd0;
  localparam logic [IDX_W-1:0] REG_VERT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_ALIGN = 2'd2;
  localparam logic [IDX_W-1:0] REG_EM    = 2'd3;

  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  localparam logic [ADV_W-1:0] EM_RESET = 22'd1024;

  localparam logic [CP_W-1:0] NO_START [24] = '{
    21'h3001, 21'h3002, 21'hFF0C, 21'hFF0E, 21'h30FB, 21'hFF65, 21'hFF1A, 21'hFF1B,
    21'hFF1F, 21'hFF01, 21'h3009, 21'h300B, 21'h300D, 21'h300F, 21'h3011, 21'h3015,
    21'hFF09, 21'hFF3D, 21'hFF5D, 21'h2026, 21'h2025, 21'h30FC, 21'h2019, 21'h201D
  };
  localparam logic [CP_W-1:0] NO_END [11] = '{
    21'h3008, 21'h300A, 21'h300C, 21'h300E, 21'h3010, 21'h3014,
    21'hFF08, 21'hFF3B, 21'hFF5B, 21'h2018, 21'h201C
  };

  typedef enum logic [4:0] {
    OP_LOAD, OP_INIT, OP_LOOP, OP_GLYPH, OP_K1, OP_K2, OP_K2B, OP_K3, OP_K4,
    OP_PUSHK, OP_SKIP, OP_SKIPD, OP_PULL, OP_PULLD, OP_RECOMP, OP_RLOOP,
    OP_RACC, OP_FINAL, OP_ORD, OP_OAL, OP_OEM
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic i_ge_n;
    logic i_lt_ls;
    logic forced;
    logic over;
    logic brk_ok;
    logic b1_lt_n;
    logic nls_b1;
    logic skip_ok;
    logic is_sp;
    logic pull_ok;
    logic nls_cp;
    logic j_le_i;
    logic k_done;
  } status_t;

  function automatic logic is_space(input logic [CP_W-1:0] c);
    return c == 21'h20 || c == 21'h09;
  endfunction

  function automatic logic is_forced(input logic [CP_W-1:0] c);
    return c == 21'h0A || c == 21'h0D;
  endfunction

  function automatic logic is_opp(input logic [CP_W-1:0] c);
    return is_space(c) || (c >= 21'h3040 && c <= 21'h30FF) ||
           (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
           (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'hFF00 && c <= 21'hFFEF);
  endfunction

  function automatic logic no_start(input logic [CP_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 24; k++) hit = hit | (NO_START[k] == c);
    hit = hit || (c >= 21'h3041 && c <= 21'h3043) || (c >= 21'h3045 && c <= 21'h3049) ||
          c == 21'h3063 || c == 21'h308E || (c >= 21'h3083 && c <= 21'h3087) ||
          (c >= 21'h30A1 && c <= 21'h30A3) || (c >= 21'h30A5 && c <= 21'h30A9) ||
          c == 21'h30C3 || c == 21'h30EE || (c >= 21'h30E3 && c <= 21'h30E7) ||
          c == 21'h30F5 || c == 21'h30F6;
    return hit;
  endfunction

  function automatic logic no_end(input logic [CP_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 11; k++) hit = hit | (NO_END[k] == c);
    return hit;
  endfunction

endpackage

[sv/klb_ram.sv]
// Generic simple dual-port RAM with registered read.
module klb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/klb_ctrl.sv]
// Sequencer for load, greedy layout with kinsoku and line readout.
module klb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  klb_pkg::status_t st,
  output klb_pkg::cmd_t    cmd,
  output logic             busy
);
  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_LOOP, S_GLYPH, S_K1, S_K2, S_K2B, S_K3, S_K4, S_PUSHK,
    S_SKIP, S_SKIPD, S_PULL, S_PULLD, S_RECOMP, S_RLOOP, S_RACC, S_FINAL,
    S_ORD, S_OAL, S_OEM
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd.accept = (state == S_IDLE) && start;
    case (state)
      S_IDLE:   cmd.op = klb_pkg::OP_LOAD;
      S_INIT:   cmd.op = klb_pkg::OP_INIT;
      S_LOOP:   cmd.op = klb_pkg::OP_LOOP;
      S_GLYPH:  cmd.op = klb_pkg::OP_GLYPH;
      S_K1:     cmd.op = klb_pkg::OP_K1;
      S_K2:     cmd.op = klb_pkg::OP_K2;
      S_K2B:    cmd.op = klb_pkg::OP_K2B;
      S_K3:     cmd.op = klb_pkg::OP_K3;
      S_K4:     cmd.op = klb_pkg::OP_K4;
      S_PUSHK:  cmd.op = klb_pkg::OP_PUSHK;
      S_SKIP:   cmd.op = klb_pkg::OP_SKIP;
      S_SKIPD:  cmd.op = klb_pkg::OP_SKIPD;
      S_PULL:   cmd.op = klb_pkg::OP_PULL;
      S_PULLD:  cmd.op = klb_pkg::OP_PULLD;
      S_RECOMP: cmd.op = klb_pkg::OP_RECOMP;
      S_RLOOP:  cmd.op = klb_pkg::OP_RLOOP;
      S_RACC:   cmd.op = klb_pkg::OP_RACC;
      S_FINAL:  cmd.op = klb_pkg::OP_FINAL;
      S_ORD:    cmd.op = klb_pkg::OP_ORD;
      S_OAL:    cmd.op = klb_pkg::OP_OAL;
      S_OEM:    cmd.op = klb_pkg::OP_OEM;
      default:  cmd.op = klb_pkg::OP_LOAD;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start && st.last) state_next = S_INIT;
      S_INIT:   state_next = S_LOOP;
      S_LOOP:   if (st.i_ge_n) state_next = S_FINAL;
                else if (!st.i_lt_ls) state_next = S_GLYPH;
      S_GLYPH:  if (!st.forced && st.over && st.brk_ok) state_next = S_K1;
                else state_next = S_LOOP;
      S_K1:     state_next = st.b1_lt_n ? S_K2 : S_K3;
      S_K2:     state_next = st.nls_b1 ? S_K2B : S_K3;
      S_K2B:    state_next = S_K3;
      S_K3:     state_next = S_K4;
      S_K4:     state_next = S_PUSHK;
      S_PUSHK:  state_next = S_SKIP;
      S_SKIP:   state_next = st.skip_ok ? S_SKIPD : S_PULL;
      S_SKIPD:  state_next = st.is_sp ? S_SKIP : S_PULL;
      S_PULL:   state_next = st.pull_ok ? S_PULLD : S_RECOMP;
      S_PULLD:  state_next = st.nls_cp ? S_PULL : S_RECOMP;
      S_RECOMP: state_next = S_RLOOP;
      S_RLOOP:  state_next = st.j_le_i ? S_RACC : S_LOOP;
      S_RACC:   state_next = S_RLOOP;
      S_FINAL:  state_next = S_ORD;
      S_ORD:    state_next = st.k_done ? S_IDLE : S_OAL;
      S_OAL:    state_next = S_OEM;
      S_OEM:    state_next = S_ORD;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE)) else $error("busy out of step with state");
  a_out_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_OAL |=> state == S_OEM ##1 state == S_ORD)
    else $error("line readout sequence broken");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !busy) else $error("transaction taken while busy");
endmodule

[sv/klb_dpath.sv]
// Glyph store, layout registers, line table and result registers.
module klb_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  klb_pkg::cmd_t                cmd,
  output klb_pkg::status_t             st,
  input  logic                         cfg_write,
  input  logic [klb_pkg::IDX_W-1:0]    cfg_index,
  input  logic [klb_pkg::CFG_W-1:0]    cfg_data,
  input  logic [klb_pkg::CP_W-1:0]     codepoint,
  input  logic [klb_pkg::ADV_W-1:0]    advance,
  input  logic                         last_glyph,
  output logic                         line_valid,
  output logic [klb_pkg::CNT_W-1:0]    line_start,
  output logic [klb_pkg::CNT_W-1:0]    line_end,
  output logic [klb_pkg::OEXT_W-1:0]   line_extent,
  output logic signed [klb_pkg::OFS_W-1:0] align_offset,
  output logic                         last_line
);
  localparam int CNT_W = klb_pkg::CNT_W;
  localparam int EXT_W = klb_pkg::EXT_W;
  localparam int DW    = EXT_W + 2;

  logic [klb_pkg::ADV_W-1:0] wrap_extent, em_size;
  logic                      vertical_mode;
  logic [1:0]                align_mode;

  logic [CNT_W-1:0] gcnt, n, ls, i, b, j;
  logic [klb_pkg::LCNT_W-1:0] lc, k;
  logic [EXT_W-1:0] run, atb, w, last_ext;
  logic [CNT_W-1:0] last_start;
  logic             hb;

  // glyph store
  logic                          gwe;
  logic [klb_pkg::GADDR_W-1:0]   graddr;
  logic [klb_pkg::GW-1:0]        grdata;
  logic [klb_pkg::CP_W-1:0]      cp;
  logic [klb_pkg::ADV_W-1:0]     a;

  assign gwe = cmd.accept && (gcnt < CNT_W'(klb_pkg::MAX_GLYPHS));

  klb_ram #(.WIDTH(klb_pkg::GW), .DEPTH(klb_pkg::MAX_GLYPHS)) u_glyphs (
    .clk(clk), .we(gwe), .waddr(gcnt[klb_pkg::GADDR_W-1:0]),
    .wdata({codepoint, advance}), .raddr(graddr), .rdata(grdata)
  );

  assign cp = grdata[klb_pkg::GW-1:klb_pkg::ADV_W];
  assign a  = (vertical_mode && grdata[klb_pkg::ADV_W-1:0] == '0) ? em_size
                                                              : grdata[klb_pkg::ADV_W-1:0];

  always_comb begin
    case (cmd.op)
      klb_pkg::OP_K1:    graddr = klb_pkg::GADDR_W'(b + 1'b1);
      klb_pkg::OP_K2,
      klb_pkg::OP_K3:    graddr = b[klb_pkg::GADDR_W-1:0];
      klb_pkg::OP_SKIP,
      klb_pkg::OP_PULL:  graddr = ls[klb_pkg::GADDR_W-1:0];
      klb_pkg::OP_RLOOP: graddr = j[klb_pkg::GADDR_W-1:0];
      default:           graddr = i[klb_pkg::GADDR_W-1:0];
    endcase
  end

  // glyph-level status
  logic [EXT_W-1:0] run_new;
  logic             opp, hb_new;
  logic [CNT_W-1:0] b_new;

  assign run_new = run + EXT_W'(a);
  assign opp     = klb_pkg::is_opp(cp);
  assign hb_new  = hb | opp;
  assign b_new   = opp ? i : b;

  always_comb begin
    st.last    = last_glyph;
    st.i_ge_n  = i >= n;
    st.i_lt_ls = i < ls;
    st.forced  = klb_pkg::is_forced(cp);
    st.over    = (wrap_extent != '0) && (run_new > EXT_W'(wrap_extent));
    st.brk_ok  = hb_new && (b_new >= ls);
    st.b1_lt_n = CNT_W'(b + 1'b1) < n;
    st.nls_b1  = klb_pkg::no_start(cp) && (b > ls);
    st.skip_ok = !vertical_mode && (ls < n);
    st.is_sp   = klb_pkg::is_space(cp);
    st.pull_ok = (ls < n) && (lc != '0);
    st.nls_cp  = klb_pkg::no_start(cp);
    st.j_le_i  = j <= i;
    st.k_done  = k >= lc;
  end

  // line table writes: new lines and pull-in updates of the last line
  logic             push_en, push_ok, pull_en;
  logic [CNT_W-1:0] push_s, push_e;
  logic [EXT_W-1:0] push_w;
  logic             lwe;
  logic [klb_pkg::LADDR_W-1:0] lwaddr;
  logic [klb_pkg::LW-1:0]      lwdata, lrdata;

  always_comb begin
    push_en = 1'b0;
    push_s  = ls;
    push_e  = i;
    push_w  = run;
    case (cmd.op)
      klb_pkg::OP_GLYPH: push_en = st.forced || (st.over && !st.brk_ok);
      klb_pkg::OP_PUSHK: begin
        push_en = 1'b1;
        push_e  = CNT_W'(b + 1'b1);
        push_w  = w;
      end
      klb_pkg::OP_FINAL: begin
        push_en = ls < n;
        push_e  = n;
      end
      default: push_en = 1'b0;
    endcase
    push_ok = push_en && (lc < klb_pkg::LCNT_W'(klb_pkg::MAX_LINES));
    pull_en = (cmd.op == klb_pkg::OP_PULLD) && st.nls_cp;
    if (pull_en) begin
      lwaddr = klb_pkg::LADDR_W'(lc - 1'b1);
      lwdata = {last_start, CNT_W'(ls + 1'b1), last_ext + EXT_W'(a)};
    end else begin
      lwaddr = lc[klb_pkg::LADDR_W-1:0];
      lwdata = {push_s, push_e, push_w};
    end
    lwe = push_ok || pull_en;
  end

  klb_ram #(.WIDTH(klb_pkg::LW), .DEPTH(klb_pkg::MAX_LINES)) u_lines (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
    .raddr(k[klb_pkg::LADDR_W-1:0]), .rdata(lrdata)
  );

  // alignment of the line read back
  logic [EXT_W-1:0]      r_ext;
  logic signed [DW-1:0]  d, dsel;

  assign r_ext = lrdata[EXT_W-1:0];
  assign d     = $signed({2'b00, EXT_W'(wrap_extent)}) - $signed({2'b00, r_ext});

  always_comb begin
    if (vertical_mode || wrap_extent == '0) dsel = '0;
    else if (align_mode == klb_pkg::ALIGN_CENTER) dsel = d >>> 1;
    else if (align_mode == klb_pkg::ALIGN_RIGHT) dsel = d;
    else dsel = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_extent   <= '0;
      vertical_mode <= 1'b0;
      align_mode    <= '0;
      em_size       <= klb_pkg::EM_RESET;
      gcnt          <= '0;
      line_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          klb_pkg::REG_WRAP:  wrap_extent   <= cfg_data;
          klb_pkg::REG_VERT:  vertical_mode <= cfg_data[0];
          klb_pkg::REG_ALIGN: align_mode    <= cfg_data[1:0];
          klb_pkg::REG_EM:    em_size       <= cfg_data;
          default:            wrap_extent   <= wrap_extent;
        endcase
      end
      line_valid <= (cmd.op == klb_pkg::OP_OAL);
      if (gwe) gcnt <= gcnt + 1'b1;
      if (cmd.op == klb_pkg::OP_ORD && st.k_done) gcnt <= '0;
    end
  end

  // layout registers: control is sequenced, so no reset is needed here
  always_ff @(posedge clk) begin
    if (cmd.accept && last_glyph) n <= gwe ? CNT_W'(gcnt + 1'b1) : gcnt;
    if (push_ok) begin
      lc         <= lc + 1'b1;
      last_start <= push_s;
      last_ext   <= push_w;
    end
    case (cmd.op)
      klb_pkg::OP_INIT: begin
        ls  <= '0;
        i   <= '0;
        run <= '0;
        hb  <= 1'b0;
        lc  <= '0;
      end
      klb_pkg::OP_LOOP: if (!st.i_ge_n && st.i_lt_ls) i <= i + 1'b1;
      klb_pkg::OP_GLYPH: begin
        if (st.forced) begin
          ls  <= CNT_W'(i + 1'b1);
          run <= '0;
          hb  <= 1'b0;
          i   <= i + 1'b1;
        end else if (st.over && !st.brk_ok) begin
          // no usable break: the glyph opens the next line
          ls  <= i;
          run <= EXT_W'(a);
          hb  <= 1'b0;
          i   <= i + 1'b1;
        end else begin
          run <= run_new;
          if (opp) begin
            hb  <= 1'b1;
            b   <= i;
            atb <= run_new;
          end
          if (!st.over) i <= i + 1'b1;
        end
      end
      klb_pkg::OP_K1:  w <= atb;
      klb_pkg::OP_K2B: begin
        w <= w - EXT_W'(a);
        b <= b - 1'b1;
      end
      klb_pkg::OP_K4: if (klb_pkg::no_end(cp) && b > ls) begin
        w <= w - EXT_W'(a);
        b <= b - 1'b1;
      end
      klb_pkg::OP_PUSHK: ls <= CNT_W'(b + 1'b1);
      klb_pkg::OP_SKIPD: if (st.is_sp) ls <= ls + 1'b1;
      klb_pkg::OP_PULLD: if (pull_en) begin
        last_ext <= last_ext + EXT_W'(a);
        ls       <= ls + 1'b1;
      end
      klb_pkg::OP_RECOMP: begin
        run <= '0;
        j   <= ls;
      end
      klb_pkg::OP_RLOOP: if (!st.j_le_i) begin
        hb <= 1'b0;
        i  <= i + 1'b1;
      end
      klb_pkg::OP_RACC: begin
        run <= run + EXT_W'(a);
        j   <= j + 1'b1;
      end
      klb_pkg::OP_FINAL: k <= '0;
      klb_pkg::OP_OAL: begin
        line_start  <= lrdata[klb_pkg::LW-1 -: CNT_W];
        line_end    <= lrdata[EXT_W +: CNT_W];
        line_extent <= (r_ext[EXT_W-1:klb_pkg::OEXT_W] != '0) ? '1
                                                              : r_ext[klb_pkg::OEXT_W-1:0];
        if (dsel > $signed(DW'((1 << (klb_pkg::OFS_W - 1)) - 1)))
          align_offset <= {1'b0, {(klb_pkg::OFS_W-1){1'b1}}};
        else if (dsel < -$signed(DW'(1 << (klb_pkg::OFS_W - 1))))
          align_offset <= {1'b1, {(klb_pkg::OFS_W-1){1'b0}}};
        else
          align_offset <= dsel[klb_pkg::OFS_W-1:0];
        last_line   <= (klb_pkg::LCNT_W'(k + 1'b1) == lc);
      end
      klb_pkg::OP_OEM: k <= k + 1'b1;
      default: ;
    endcase
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    line_valid |=> !line_valid) else $error("result strobe held two cycles");
  a_range: assert property (@(posedge clk) disable iff (rst)
    line_valid |-> line_end >= line_start) else $error("line range reversed");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    gcnt <= CNT_W'(klb_pkg::MAX_GLYPHS)) else $error("glyph count overrun");
endmodule

[sv/kinsoku_line_breaker.sv]
// Top level of the kinsoku line breaker: controller plus datapath.
// Loading takes one glyph per cycle; start is taken whenever busy is low.
// The glyph marked last starts layout: each stored glyph is read through the single
// read port of the glyph RAM, the glyphs after each kinsoku wrap are walked again,
// and the lines are then read out through the ORD, OAL and OEM states.
// Each line is shown for one cycle on line_valid; the receiver cannot stall.
// Synchronous reset clears control and configuration; the RAMs are not cleared.
module kinsoku_line_breaker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [klb_pkg::CP_W-1:0]       codepoint,
  input  logic [klb_pkg::ADV_W-1:0]      advance,
  input  logic                           last_glyph,
  input  logic                           cfg_write,
  input  logic [klb_pkg::IDX_W-1:0]      cfg_index,
  input  logic [klb_pkg::CFG_W-1:0]      cfg_data,
  output logic                           line_valid,
  output logic [klb_pkg::CNT_W-1:0]      line_start,
  output logic [klb_pkg::CNT_W-1:0]      line_end,
  output logic [klb_pkg::OEXT_W-1:0]     line_extent,
  output logic signed [klb_pkg::OFS_W-1:0] align_offset,
  output logic                           last_line
);
  // command from the sequencer, status back from the datapath
  klb_pkg::cmd_t    cmd;
  klb_pkg::status_t st;

  klb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .cmd(cmd), .busy(busy)
  );

  // one transaction per glyph; results leave as one transaction per line
  klb_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .codepoint(codepoint), .advance(advance), .last_glyph(last_glyph),
    .line_valid(line_valid), .line_start(line_start), .line_end(line_end),
    .line_extent(line_extent), .align_offset(align_offset), .last_line(last_line)
  );
endmodule
